// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the life generation stencil. They expand to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// clocked property, off while reset is high
`define LGS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// clocked property, checked in reset too
`define LGS_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LGS_ASSERT(lbl, clk, rst, prop, msg)
`define LGS_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

// ----- hdl/lgs_pkg.sv -----
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared constants and types of the life generation stencil.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lgs_pkg;

  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int AGE_PORT_W = 8;
  localparam int POS_PORT_W = 10;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_AGE_BITS   = 8;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] RESET_FRAME_WIDTH  = 11'd64;
  localparam logic [CFG_W-1:0] RESET_FRAME_HEIGHT = 11'd64;

  // per-item control bits from the scan stage to the window stage
  typedef struct packed {
    logic col0;    // first column of an input row
    logic emit;    // item produces a result
    logic last;    // result is the final cell of the frame
    logic top_ok;  // row two above is inside the frame
    logic mid_ok;  // row above is inside the frame
    logic bot;     // incoming cell is alive and inside the frame
  } lgs_flags_t;

endpackage

// ----- hdl/lgs_in_if.sv -----
// ----------------------------------------------------------------------------
// lgs_in_if
// Request channel carrying previous-generation cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lgs_in_if import lgs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [AGE_PORT_W-1:0] cell_age;
  logic                  drain;

  modport source (output valid, output cell_age, output drain, input ready);
  modport sink   (input valid, input cell_age, input drain, output ready);
endinterface

// ----- hdl/lgs_out_if.sv -----
// ----------------------------------------------------------------------------
// lgs_out_if
// Request channel carrying next-generation cells with their position.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lgs_out_if import lgs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [AGE_PORT_W-1:0] next_age;
  logic [POS_PORT_W-1:0] cell_row;
  logic [POS_PORT_W-1:0] cell_column;
  logic                  last_of_frame;

  modport source (output valid, output next_age, output cell_row, output cell_column,
                  output last_of_frame, input ready);
  modport sink   (input valid, input next_age, input cell_row, input cell_column,
                  input last_of_frame, output ready);
endinterface

// ----- hdl/lgs_line_store.sv -----
// ----------------------------------------------------------------------------
// lgs_line_store
// Line store memory: one read and one write per cycle, registered read,
// with a bypass when a read hits the entry written in the same cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lgs_line_store import lgs_pkg::*; #(
  parameter  int DEPTH  = DEF_MAX_WIDTH,
  parameter  int DATA_W = DEF_AGE_BITS + 1,
  localparam int AW     = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_q;
  logic [DATA_W-1:0] byp_q;
  logic              hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
    if (rd_en && wr_en) begin
      byp_q <= wr_data;
    end
  end

  // read before write on a collision: take the data being written instead
  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (rd_en) begin
      hit <= wr_en && (rd_addr == wr_addr);
    end
  end

  assign rd_data = hit ? byp_q : rd_q;

endmodule

// ----- hdl/lgs_scan.sv -----
// ----------------------------------------------------------------------------
// lgs_scan
// Size registers, raster counters and the first pipeline stage: issues the
// line store read and precomputes masks and the output position.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lgs_scan import lgs_pkg::*; #(
  parameter  int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter  int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter  int AGE_BITS   = DEF_AGE_BITS,
  localparam int CW         = $clog2(MAX_WIDTH),
  localparam int RW         = $clog2(MAX_HEIGHT + 2)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  lgs_in_if.sink               cell_in,
  input  logic                 b_fire,
  output logic                 rd_en,
  output logic [CW-1:0]        rd_addr,
  output logic                 a_valid,
  output lgs_flags_t           a_flags,
  output logic [CW-1:0]        a_col,
  output logic [AGE_BITS-1:0]  a_v,
  output logic [RW-1:0]        a_er,
  output logic [CW-1:0]        a_ec
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  logic [CFG_W-1:0]    width_q;
  logic [CFG_W-1:0]    height_q;
  logic [WW-1:0]       w;
  logic [HW-1:0]       h;
  logic [RW-1:0]       row_q;
  logic [RW-1:0]       row_c;
  logic [RW-1:0]       row_next;
  logic [CW-1:0]       col_q;
  logic [CW-1:0]       col_c;
  logic [CW-1:0]       col_next;
  logic                restart;
  logic                in_fire;
  logic [AGE_BITS-1:0] v;
  lgs_flags_t          flags;
  logic [RW-1:0]       er;
  logic [CW-1:0]       ec;

  always_comb begin
    if (width_q == '0) begin
      w = WW'(1);
    end else if (int'(width_q) > MAX_WIDTH) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(width_q);
    end
    if (height_q == '0) begin
      h = HW'(1);
    end else if (int'(height_q) > MAX_HEIGHT) begin
      h = HW'(MAX_HEIGHT);
    end else begin
      h = HW'(height_q);
    end
  end

  // a size change can leave the counters off the frame: start over
  assign restart = (int'(col_q) >= int'(w)) || (int'(row_q) > int'(h) + 1) ||
                   ((int'(row_q) == int'(h) + 1) && (col_q != '0));
  assign row_c   = restart ? '0 : row_q;
  assign col_c   = restart ? '0 : col_q;

  assign cell_in.ready = !a_valid || b_fire;
  assign in_fire       = cell_in.valid && cell_in.ready;
  assign rd_en         = in_fire;
  assign rd_addr       = col_c;

  assign v = cell_in.drain ? '0 : AGE_BITS'(cell_in.cell_age);

  always_comb begin
    flags.col0   = (col_c == '0);
    flags.top_ok = (int'(row_c) >= 2);
    flags.mid_ok = (int'(row_c) >= 1) && (int'(row_c) <= int'(h));
    flags.bot    = (int'(row_c) < int'(h)) && (v != '0);
    if (flags.col0) begin
      // closes the previous row at its right edge
      flags.emit = (int'(row_c) >= 2);
      er         = RW'(int'(row_c) - 2);
      ec         = CW'(int'(w) - 1);
    end else begin
      flags.emit = (int'(row_c) >= 1);
      er         = RW'(int'(row_c) - 1);
      ec         = col_c - CW'(1);
    end
    flags.last = flags.emit && (int'(er) == int'(h) - 1) && (int'(ec) == int'(w) - 1);

    if (int'(row_c) == int'(h) + 1) begin
      row_next = '0;
      col_next = '0;
    end else if (int'(col_c) + 1 >= int'(w)) begin
      row_next = row_c + RW'(1);
      col_next = '0;
    end else begin
      row_next = row_c;
      col_next = col_c + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_q  <= RESET_FRAME_WIDTH;
      height_q <= RESET_FRAME_HEIGHT;
      row_q    <= '0;
      col_q    <= '0;
      a_valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  width_q  <= cfg_data;
          REG_FRAME_HEIGHT: height_q <= cfg_data;
          default: ;
        endcase
      end
      if (in_fire) begin
        row_q   <= row_next;
        col_q   <= col_next;
        a_valid <= 1'b1;
      end else if (b_fire) begin
        a_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_flags <= flags;
      a_col   <= col_c;
      a_v     <= v;
      a_er    <= er;
      a_ec    <= ec;
    end
  end

  `LGS_ASSERT(a_scan_load, clk, rst, in_fire |=> a_valid, "accepted request not staged")
  `LGS_ASSERT(a_scan_hold, clk, rst, a_valid && !b_fire |=> a_valid && $stable(a_col) && $stable(a_v), "staged item lost while stalled")
  `LGS_ASSERT_NR(a_scan_empty_ready, clk, !a_valid |-> cell_in.ready, "empty stage not ready")

endmodule

// ----- hdl/lgs_window.sv -----
// ----------------------------------------------------------------------------
// lgs_window
// Second pipeline stage: 3x3 window update, B3/S23 rule with ages, line
// store write-back data and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lgs_window import lgs_pkg::*; #(
  parameter  int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter  int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter  int AGE_BITS   = DEF_AGE_BITS,
  localparam int CW         = $clog2(MAX_WIDTH),
  localparam int RW         = $clog2(MAX_HEIGHT + 2)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                a_valid,
  input  lgs_flags_t          a_flags,
  input  logic [AGE_BITS-1:0] a_v,
  input  logic [RW-1:0]       a_er,
  input  logic [CW-1:0]       a_ec,
  input  logic [AGE_BITS:0]   rd_data,
  output logic                b_fire,
  output logic [AGE_BITS:0]   wr_data,
  lgs_out_if.source           cell_out
);

  localparam logic [3:0] SURVIVE_LOW = 4'd2;
  localparam logic [3:0] BIRTH_COUNT = 4'd3;

  logic [AGE_BITS-1:0] wc1;
  logic [AGE_BITS-1:0] wc2;
  logic [5:0]          outer_q;
  logic [AGE_BITS-1:0] wc1_next;
  logic [AGE_BITS-1:0] wc2_next;
  logic [5:0]          outer_next;

  logic [AGE_BITS-1:0] center_rd;
  logic                upper_rd;
  logic                top;
  logic [AGE_BITS-1:0] midage;
  logic [AGE_BITS-1:0] mid0;
  logic [AGE_BITS-1:0] mid1;
  logic [AGE_BITS-1:0] mid2;
  logic [5:0]          outer;
  logic [3:0]          n;
  logic [AGE_BITS-1:0] age_next;

  assign b_fire = a_valid && (!cell_out.valid || cell_out.ready);

  assign center_rd = rd_data[AGE_BITS-1:0];
  assign upper_rd  = rd_data[AGE_BITS];
  assign top       = a_flags.top_ok && upper_rd;
  assign midage    = a_flags.mid_ok ? center_rd : '0;
  // the row above moves up, the incoming cell becomes the row above
  assign wr_data   = {center_rd != '0, a_v};

  always_comb begin
    mid0 = wc1;
    mid1 = wc2;
    mid2 = a_flags.col0 ? '0 : midage;
    // bits 0..2 top row, 3..5 bottom row; a first column sees a dead right edge
    outer = {a_flags.bot && !a_flags.col0, outer_q[5:4],
             top && !a_flags.col0, outer_q[2:1]};
    n = 4'(outer[0]) + 4'(outer[1]) + 4'(outer[2]) + 4'(outer[3]) + 4'(outer[4]) +
        4'(outer[5]) + 4'(mid0 != '0) + 4'(mid2 != '0);

    if (mid1 != '0) begin
      if (n == SURVIVE_LOW || n == BIRTH_COUNT) begin
        age_next = (&mid1) ? mid1 : mid1 + AGE_BITS'(1);
      end else begin
        age_next = '0;
      end
    end else begin
      age_next = (n == BIRTH_COUNT) ? AGE_BITS'(1) : '0;
    end

    if (a_flags.col0) begin
      wc1_next   = '0;
      wc2_next   = midage;
      outer_next = {a_flags.bot, 2'b00, top, 2'b00};
    end else begin
      wc1_next   = mid1;
      wc2_next   = mid2;
      outer_next = outer;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wc1            <= '0;
      wc2            <= '0;
      outer_q        <= '0;
      cell_out.valid <= 1'b0;
    end else if (b_fire) begin
      wc1            <= wc1_next;
      wc2            <= wc2_next;
      outer_q        <= outer_next;
      cell_out.valid <= a_flags.emit;
    end else if (cell_out.ready) begin
      cell_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire) begin
      cell_out.next_age      <= AGE_PORT_W'(age_next);
      cell_out.cell_row      <= POS_PORT_W'(a_er);
      cell_out.cell_column   <= POS_PORT_W'(a_ec);
      cell_out.last_of_frame <= a_flags.last;
    end
  end

  `LGS_ASSERT(a_win_emit, clk, rst, b_fire && a_flags.emit |=> cell_out.valid, "result not presented")
  `LGS_ASSERT(a_win_silent, clk, rst, b_fire && !a_flags.emit |=> !cell_out.valid, "result invented")
  `LGS_ASSERT(a_win_row_start, clk, rst, b_fire && a_flags.col0 |=> wc1 == '0, "left edge not dead")

endmodule

// ----- hdl/life_generation_stencil.sv -----
// ----------------------------------------------------------------------------
// life_generation_stencil
// One Game of Life generation (B3/S23) with cell ages over a raster stream.
// Request k+width+1 completes cell k's window, then passes the scan stage
// and output registers; width+1 drain requests end a frame. Throughput: one
// request per cycle unless stalled, set by the line store doing one read and
// one write each cycle. Reset: counters, window and valid flags clear, size
// 64x64; the line store is not cleared, unwritten rows are masked.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module life_generation_stencil import lgs_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int AGE_BITS   = DEF_AGE_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  lgs_in_if.sink               cell_in,
  lgs_out_if.source            cell_out
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT + 2);

  logic                rd_en;
  logic [CW-1:0]       rd_addr;
  logic [AGE_BITS:0]   rd_data;
  logic [AGE_BITS:0]   wr_data;
  logic                b_fire;
  logic                a_valid;
  lgs_flags_t          a_flags;
  logic [CW-1:0]       a_col;
  logic [AGE_BITS-1:0] a_v;
  logic [RW-1:0]       a_er;
  logic [CW-1:0]       a_ec;

  lgs_scan #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .AGE_BITS   (AGE_BITS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cell_in   (cell_in),
    .b_fire    (b_fire),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .a_valid   (a_valid),
    .a_flags   (a_flags),
    .a_col     (a_col),
    .a_v       (a_v),
    .a_er      (a_er),
    .a_ec      (a_ec)
  );

  // entry: {live bit of the row two above, age of the row above}
  lgs_line_store #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (AGE_BITS + 1)
  ) u_line_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .wr_en   (b_fire),
    .wr_addr (a_col),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  lgs_window #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .AGE_BITS   (AGE_BITS)
  ) u_window (
    .clk      (clk),
    .rst      (rst),
    .a_valid  (a_valid),
    .a_flags  (a_flags),
    .a_v      (a_v),
    .a_er     (a_er),
    .a_ec     (a_ec),
    .rd_data  (rd_data),
    .b_fire   (b_fire),
    .wr_data  (wr_data),
    .cell_out (cell_out)
  );

endmodule
